@@ sv/hcbd_pkg.sv @@
// Shared types, constants and character tables for the chunked body decoder.
`default_nettype none

package hcbd_pkg;

	// Payload of one input transfer
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	// Payload of one output transfer
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// Work handed from the parser to the emitter
	typedef struct packed {
		logic       emit;    // pass data as an output byte
		logic [7:0] data;
		logic       append;  // follow with CR LF CR LF
		logic       last;    // final command of the request
	} cmd_t;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	localparam int KEY_LEN     = 26;
	localparam int END_LEN     = 4;
	localparam int QUEUE_DEPTH = 4;

	// Characters of "Transfer-Encoding: chunked"
	function automatic logic [7:0] key_char(input logic [4:0] idx);
		logic [7:0] c;
		case (idx)
			5'd0:    c = "T";
			5'd1:    c = "r";
			5'd2:    c = "a";
			5'd3:    c = "n";
			5'd4:    c = "s";
			5'd5:    c = "f";
			5'd6:    c = "e";
			5'd7:    c = "r";
			5'd8:    c = "-";
			5'd9:    c = "E";
			5'd10:   c = "n";
			5'd11:   c = "c";
			5'd12:   c = "o";
			5'd13:   c = "d";
			5'd14:   c = "i";
			5'd15:   c = "n";
			5'd16:   c = "g";
			5'd17:   c = ":";
			5'd18:   c = " ";
			5'd19:   c = "c";
			5'd20:   c = "h";
			5'd21:   c = "u";
			5'd22:   c = "n";
			5'd23:   c = "k";
			5'd24:   c = "e";
			5'd25:   c = "d";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Characters of CR LF CR LF
	function automatic logic [7:0] end_char(input logic [1:0] idx);
		return idx[0] ? CHAR_LF : CHAR_CR;
	endfunction

	// Hex digit value; anything else counts as zero
	function automatic logic [3:0] hex_value(input logic [7:0] b);
		logic [3:0] v;
		v = 4'd0;
		if (b >= "0" && b <= "9")
			v = 4'(b - 8'h30);
		else if (b >= "a" && b <= "f")
			v = 4'(b - 8'h57);
		else if (b >= "A" && b <= "F")
			v = 4'(b - 8'h37);
		return v;
	endfunction

endpackage

`default_nettype wire

@@ sv/hcbd_front.sv @@
// Parser: tracks header and chunk framing, classifies each byte into a command.
`default_nettype none

module hcbd_front #(
	parameter int SIZE_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              src_valid,
	output logic                   src_ready,
	input  wire hcbd_pkg::in_item_t src_item,
	input  wire logic              q_full,
	output logic                   push,
	output hcbd_pkg::cmd_t         push_cmd
);
	import hcbd_pkg::*;

	typedef enum logic [5:0] {
		PH_HEADER    = 6'b000001,
		PH_PLAIN     = 6'b000010,
		PH_SIZE      = 6'b000100,
		PH_SKIP_SIZE = 6'b001000,
		PH_DATA      = 6'b010000,
		PH_SKIP_DATA = 6'b100000
	} phase_t;

	phase_t               phase_q, phase_n;
	logic [4:0]           key_q, key_n;
	logic [1:0]           end_q, end_n;
	logic                 chunked_q, chunked_n;
	logic [SIZE_BITS-1:0] chunk_q, chunk_n;
	logic [1:0]           skip_q, skip_n;

	logic       emit;
	logic       append;
	logic       accept;
	logic [7:0] b;
	logic [5:0] key_inc;
	logic [2:0] end_inc;
	logic [1:0] skip_dec;
	logic [SIZE_BITS-1:0] chunk_dec;

	assign b         = src_item.in_byte;
	assign src_ready = !q_full;
	assign accept    = src_valid && src_ready;
	assign key_inc   = {1'b0, key_q} + 6'd1;
	assign end_inc   = {1'b0, end_q} + 3'd1;
	assign skip_dec  = (skip_q != 2'd0) ? skip_q - 2'd1 : 2'd0;
	assign chunk_dec = (chunk_q != '0) ? chunk_q - 1'b1 : '0;

	// Next-state and classification for the byte on the input
	always_comb begin
		phase_n   = phase_q;
		key_n     = key_q;
		end_n     = end_q;
		chunked_n = chunked_q;
		chunk_n   = chunk_q;
		skip_n    = skip_q;
		emit      = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				emit = 1'b1;
				// keyword search
				if (key_inc <= 6'(KEY_LEN) && b == key_char(key_q))
					key_n = key_inc[4:0];
				else
					key_n = (b == key_char(5'd0)) ? 5'd1 : 5'd0;
				if (key_n == 5'(KEY_LEN)) begin
					chunked_n = 1'b1;
					key_n     = 5'd0;
				end
				// end-of-header search
				if (b == end_char(end_q) && end_inc == 3'(END_LEN)) begin
					end_n   = 2'd0;
					chunk_n = '0;
					phase_n = chunked_n ? PH_SIZE : PH_PLAIN;
				end else if (b == end_char(end_q)) begin
					end_n = end_inc[1:0];
				end else begin
					end_n = (b == CHAR_CR) ? 2'd1 : 2'd0;
				end
			end
			PH_PLAIN: begin
				emit = 1'b1;
			end
			PH_SIZE: begin
				if (b == CHAR_CR) begin
					phase_n = PH_SKIP_SIZE;
					skip_n  = 2'd1;
				end else if (|chunk_q[SIZE_BITS-1 -: 4]) begin
					chunk_n = '1;
				end else begin
					chunk_n = {chunk_q[SIZE_BITS-5:0], hex_value(b)};
				end
			end
			PH_SKIP_SIZE: begin
				skip_n = skip_dec;
				if (skip_dec == 2'd0) begin
					if (chunk_q == '0) begin
						phase_n = PH_SKIP_DATA;
						skip_n  = 2'd2;
					end else begin
						phase_n = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				emit    = 1'b1;
				chunk_n = chunk_dec;
				if (chunk_dec == '0) begin
					phase_n = PH_SKIP_DATA;
					skip_n  = 2'd2;
				end
			end
			PH_SKIP_DATA: begin
				skip_n = skip_dec;
				if (skip_dec == 2'd0) begin
					phase_n = PH_SIZE;
					chunk_n = '0;
				end
			end
			default: begin
				phase_n = PH_HEADER;
			end
		endcase
	end

	// Trailer only for a chunked request that got past its header
	assign append = src_item.in_last && chunked_n && (phase_n != PH_HEADER);

	assign push            = accept && (emit || append);
	assign push_cmd.emit   = emit;
	assign push_cmd.data   = b;
	assign push_cmd.append = append;
	assign push_cmd.last   = src_item.in_last;

	// State registers; the final byte returns everything to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			key_q     <= '0;
			end_q     <= '0;
			chunked_q <= 1'b0;
			chunk_q   <= '0;
			skip_q    <= '0;
		end else if (accept) begin
			if (src_item.in_last) begin
				phase_q   <= PH_HEADER;
				key_q     <= '0;
				end_q     <= '0;
				chunked_q <= 1'b0;
				chunk_q   <= '0;
				skip_q    <= '0;
			end else begin
				phase_q   <= phase_n;
				key_q     <= key_n;
				end_q     <= end_n;
				chunked_q <= chunked_n;
				chunk_q   <= chunk_n;
				skip_q    <= skip_n;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/hcbd_queue.sv @@
// Small command FIFO between parser and emitter.
`default_nettype none

module hcbd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire hcbd_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output hcbd_pkg::cmd_t     head_cmd
);
	import hcbd_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ sv/hcbd_back.sv @@
// Emitter: expands each command into output bytes behind an output register.
`default_nettype none

module hcbd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire hcbd_pkg::cmd_t head_cmd,
	output logic               pop,
	output logic               dst_valid,
	input  wire logic          dst_ready,
	output hcbd_pkg::out_item_t dst_item
);
	import hcbd_pkg::*;

	logic       valid_q;
	out_item_t  item_q;
	logic [2:0] rem_q;      // trailer bytes still to send
	logic       last_q;     // trailer belongs to the final command
	logic       slot_free;
	logic [2:0] pos;

	assign slot_free = !valid_q || dst_ready;
	assign pop       = slot_free && (rem_q == 3'd0) && head_valid;
	assign pos       = 3'(END_LEN) - rem_q;
	assign dst_valid = valid_q;
	assign dst_item  = item_q;

	// Output payload
	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (rem_q != 3'd0) begin
				item_q.out_byte <= end_char(pos[1:0]);
				item_q.out_last <= last_q && (rem_q == 3'd1);
			end else if (head_cmd.emit) begin
				item_q.out_byte <= head_cmd.data;
				item_q.out_last <= head_cmd.last && !head_cmd.append;
			end else begin
				item_q.out_byte <= end_char(2'd0);
				item_q.out_last <= 1'b0;
			end
		end
	end

	// Output valid and trailer sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= '0;
			last_q  <= 1'b0;
		end else if (slot_free) begin
			if (rem_q != 3'd0) begin
				valid_q <= 1'b1;
				rem_q   <= rem_q - 3'd1;
			end else if (head_valid) begin
				valid_q <= 1'b1;
				last_q  <= head_cmd.last;
				if (!head_cmd.append)
					rem_q <= 3'd0;
				else if (head_cmd.emit)
					rem_q <= 3'(END_LEN);
				else
					rem_q <= 3'(END_LEN - 1);
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/http_chunked_body_decoder_unit.sv @@
// Top level of the HTTP chunked body decoder: parser, command queue, emitter.
// Path: a passed byte goes from src into the command queue, then into the emitter's output register on dst.
// Throughput: one input byte per cycle while the command queue is not full; the final byte of a chunked
// request occupies the emitter for its own byte plus the CR LF CR LF trailer.
// Dropped framing bytes produce no output of their own.
// Reset: arst_n clears parser state, queue pointers and output valid at once.
`default_nettype none

module http_chunked_body_decoder_unit #(
	parameter int SIZE_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               src_valid,
	output logic                    src_ready,
	input  wire hcbd_pkg::in_item_t  src_item,
	output logic                    dst_valid,
	input  wire logic               dst_ready,
	output hcbd_pkg::out_item_t     dst_item
);
	import hcbd_pkg::*;

	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	hcbd_front #(
		.SIZE_BITS(SIZE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_item (src_item),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	hcbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	hcbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_item  (dst_item)
	);

endmodule

`default_nettype wire

@@ tb/http_chunked_body_decoder_unit_test.sv @@
// Self-checking testbench for the HTTP chunked body decoder unit.
`timescale 1ns / 100ps

module http_chunked_body_decoder_unit_test;
	import hcbd_pkg::*;

	localparam int SIZE_BITS = 32;
	localparam logic [SIZE_BITS-1:0] SIZE_SAT = '1;
	localparam logic [8*KEY_LEN-1:0] KEY_TEXT = "Transfer-Encoding: chunked";
	localparam logic [8*END_LEN-1:0] END_TEXT = "\r\n\r\n";
	localparam int RANDOM_BYTES = 60;
	localparam int IDLE_PCT = 8;

	// Parser phases of the expected-output model
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_PLAIN,
		PH_SIZE,
		PH_SKIP_SIZE,
		PH_DATA,
		PH_SKIP_DATA
	} parse_phase_t;

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_ready;
	in_item_t  src_item;
	logic      dst_valid;
	logic      dst_ready;
	out_item_t dst_item;

	// Model state
	parse_phase_t           phase;
	int                     key_hits;
	int                     crlf_hits;
	bit                     chunked_req;
	logic [SIZE_BITS-1:0]   chunk_left;
	int                     drop_left;

	out_item_t  rewritten_due[$];
	logic [7:0] req_bytes[$];
	int         mismatches;
	bit         src_idle_on;
	bit         dst_idle_on;
	bit         hold_req;
	int         hold_len;

	http_chunked_body_decoder_unit #(
		.SIZE_BITS(SIZE_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_item (src_item),
		.dst_valid(dst_valid),
		.dst_ready(dst_ready),
		.dst_item (dst_item)
	);

	// Clock
	always #2 clk = ~clk;

	// Hard limit on run time
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [7:0] key_at(input int i);
		return KEY_TEXT[8*(KEY_LEN-1-i) +: 8];
	endfunction

	function automatic logic [7:0] crlf_at(input int i);
		return END_TEXT[8*(END_LEN-1-i) +: 8];
	endfunction

	// Size digit value; non-hex characters read as zero
	function automatic logic [3:0] size_digit(input logic [7:0] b);
		if (b >= "0" && b <= "9")
			return b[3:0];
		if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
			return b[3:0] + 4'd9;
		return 4'd0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
		if (nib < 4'd10)
			return 8'h30 + nib;
		return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
	endfunction

	task automatic clear_parser();
		phase       = PH_HEADER;
		key_hits    = 0;
		crlf_hits   = 0;
		chunked_req = 1'b0;
		chunk_left  = '0;
		drop_left   = 0;
	endtask

	// Expected output bytes for one accepted input byte
	task automatic rewrite_byte(input in_item_t it);
		logic [7:0] b;
		logic [7:0] emitted[$];
		out_item_t  o;
		b = it.in_byte;
		case (phase)
			PH_HEADER: begin
				emitted.push_back(b);
				if (key_hits < KEY_LEN && b == key_at(key_hits))
					key_hits++;
				else
					key_hits = (b == key_at(0)) ? 1 : 0;
				if (key_hits >= KEY_LEN) begin
					chunked_req = 1'b1;
					key_hits    = 0;
				end
				if (crlf_hits < END_LEN && b == crlf_at(crlf_hits))
					crlf_hits++;
				else
					crlf_hits = (b == CHAR_CR) ? 1 : 0;
				if (crlf_hits >= END_LEN) begin
					crlf_hits  = 0;
					chunk_left = '0;
					phase      = chunked_req ? PH_SIZE : PH_PLAIN;
				end
			end
			PH_SIZE: begin
				if (b == CHAR_CR) begin
					phase     = PH_SKIP_SIZE;
					drop_left = 1;
				end else if (chunk_left > (SIZE_SAT >> 4)) begin
					chunk_left = SIZE_SAT;
				end else begin
					chunk_left = (chunk_left << 4) + size_digit(b);
				end
			end
			PH_SKIP_SIZE: begin
				if (drop_left > 0)
					drop_left--;
				if (drop_left == 0) begin
					if (chunk_left == '0) begin
						phase     = PH_SKIP_DATA;
						drop_left = 2;
					end else begin
						phase = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				emitted.push_back(b);
				if (chunk_left != '0)
					chunk_left--;
				if (chunk_left == '0) begin
					phase     = PH_SKIP_DATA;
					drop_left = 2;
				end
			end
			PH_SKIP_DATA: begin
				if (drop_left > 0)
					drop_left--;
				if (drop_left == 0) begin
					phase      = PH_SIZE;
					chunk_left = '0;
				end
			end
			default: begin
				emitted.push_back(b);
			end
		endcase
		// End of request: trailer for a decoded body, then back to reset state
		if (it.in_last) begin
			if (chunked_req && phase != PH_HEADER)
				for (int k = 0; k < END_LEN; k++)
					emitted.push_back(crlf_at(k));
			clear_parser();
		end
		foreach (emitted[i]) begin
			o.out_byte = emitted[i];
			o.out_last = it.in_last && (i == emitted.size() - 1);
			rewritten_due.push_back(o);
		end
	endtask

	// One input transfer, with an occasional random gap before it
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (src_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			src_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		src_valid        = 1'b1;
		src_item.in_byte = b;
		src_item.in_last = last;
		do @(posedge clk); while (!src_ready);
		rewrite_byte(src_item);
		@(negedge clk);
	endtask

	task automatic send_request();
		foreach (req_bytes[i])
			send_byte(req_bytes[i], i == req_bytes.size() - 1);
		req_bytes.delete();
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			req_bytes.push_back(s[i]);
	endtask

	task automatic put_byte(input logic [7:0] b);
		req_bytes.push_back(b);
	endtask

	task automatic put_random_bytes(input int n);
		repeat (n) req_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// Size line in hex, random letter case, no leading zeros
	task automatic put_size(input int unsigned v);
		logic [3:0] nib;
		bit         started;
		started = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			nib = v[4*i +: 4];
			if (nib != 4'd0 || started || i == 0) begin
				started = 1'b1;
				req_bytes.push_back(hex_char(nib, 1'($urandom_range(0, 1))));
			end
		end
	endtask

	task automatic put_random_header(input bit with_key);
		int lines;
		int key_pos;
		lines   = $urandom_range(0, 2);
		key_pos = $urandom_range(0, lines);
		put_text("GET /\r\n");
		for (int i = 0; i <= lines; i++) begin
			if (with_key && i == key_pos) begin
				// stray leading T exercises the match restart
				if ($urandom_range(0, 3) == 0)
					put_text("T");
				put_text("Transfer-Encoding: chunked\r\n");
			end else if (i < lines) begin
				put_text("X-");
				repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(8'h61, 8'h7A)));
				put_text(": v\r\n");
			end
		end
		put_text("\r\n");
	endtask

	// Well-formed chunked request with random content and light corruption
	task automatic put_chunked_request();
		int unsigned sz;
		put_random_header(1'b1);
		repeat ($urandom_range(1, 3)) begin
			sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 8);
			put_size(sz);
			if ($urandom_range(0, 19) == 0)
				put_text("z");
			put_byte(CHAR_CR);
			put_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CHAR_LF);
			put_random_bytes(sz);
			if ($urandom_range(0, 9) == 0) begin
				put_random_bytes(2);
			end else begin
				put_byte(CHAR_CR);
				put_byte(CHAR_LF);
			end
		end
		if ($urandom_range(0, 9) < 7)
			put_text("0\r\n\r\n");
		else
			put_random_bytes(1);
	endtask

	// Output check against the oldest expected byte
	always @(posedge clk) begin
		if (arst_n && dst_valid && dst_ready) begin
			if (rewritten_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output: byte %02h last %b",
						dst_item.out_byte, dst_item.out_last);
			end else begin
				if (dst_item.out_byte !== rewritten_due[0].out_byte ||
				    dst_item.out_last !== rewritten_due[0].out_last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected byte %02h last %b, got byte %02h last %b",
							rewritten_due[0].out_byte, rewritten_due[0].out_last,
							dst_item.out_byte, dst_item.out_last);
				end
				void'(rewritten_due.pop_front());
			end
		end
	end

	// Output ready: random idling, or a long hold-off on request
	initial begin
		dst_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				dst_ready = 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_req = 1'b0;
			end
			dst_ready = !dst_idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Plain request: body passes through, byte extremes on the data
	task automatic test_plain_passthrough();
		put_text("GET /\r\n\r\n");
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'h55);
		put_byte(8'hAA);
		send_request();
	endtask

	// Final byte still in the header: no trailer even with the keyword seen
	task automatic test_header_never_ends();
		put_text("Transfer-Encoding: chunked\r\n\r");
		put_byte(8'hFF);
		send_request();
	endtask

	// Header end on the final byte, plain and chunked
	task automatic test_header_end_on_last();
		put_text("\r\n\r\n");
		send_request();
		put_text("Transfer-Encoding: chunked\r\n\r\n");
		send_request();
	endtask

	// Chunk framing, zero chunk followed by further chunks, data ending the request
	task automatic test_chunk_framing();
		put_text("Transfer-Encoding: chunked\r\n\r\n");
		put_text("3\r\nabc\r\n");
		put_text("0\r\n\r\n");
		put_text("a\r\n");
		put_random_bytes(10);
		put_text("\r\n1\r\nZ");
		send_request();
	endtask

	// Non-hex size digits, size saturation, truncation inside a size
	task automatic test_size_edge_cases();
		put_text("Transfer-Encoding: chunked\r\n\r\n");
		put_text("g1\r\nx\r\n");
		put_text("FFFFFFFFFFF\r\n");
		put_random_bytes(3);
		send_request();
		put_text("Transfer-Encoding: chunked\r\n\r\n1F");
		send_request();
	endtask

	// Back-to-back transfers on both sides
	task automatic test_full_rate();
		src_idle_on = 1'b0;
		dst_idle_on = 1'b0;
		put_chunked_request();
		send_request();
		src_idle_on = 1'b1;
		dst_idle_on = 1'b1;
	endtask

	// Long output stall while input keeps coming
	task automatic test_output_backpressure();
		hold_len = 250;
		hold_req = 1'b1;
		put_text("GET /\r\n\r\n");
		put_random_bytes(48);
		send_request();
	endtask

	// Random mix: mostly chunked requests, some plain, some noise, some truncated
	task automatic test_random_requests();
		int sent;
		int kind;
		int cut;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				put_chunked_request();
			end else if (kind < 80) begin
				put_random_header(1'b0);
				put_random_bytes($urandom_range(0, 20));
			end else if (kind < 88) begin
				put_text("GET /\r\ntransfer-encoding: chunked\r\n\r\n4\r\nabcd\r\n");
			end else begin
				repeat ($urandom_range(1, 24))
					put_byte(($urandom_range(0, 9) < 3) ?
						(($urandom_range(0, 1) == 1) ? CHAR_CR : CHAR_LF) :
						8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 4) == 0) begin
				cut = $urandom_range(1, req_bytes.size());
				while (req_bytes.size() > cut)
					void'(req_bytes.pop_back());
			end
			sent += req_bytes.size();
			send_request();
		end
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		src_valid   = 1'b0;
		src_item    = '0;
		mismatches  = 0;
		src_idle_on = 1'b1;
		dst_idle_on = 1'b1;
		hold_req    = 1'b0;
		hold_len    = 0;
		clear_parser();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_plain_passthrough();
		test_header_never_ends();
		test_header_end_on_last();
		test_chunk_framing();
		test_size_edge_cases();
		test_full_rate();
		test_output_backpressure();
		test_random_requests();

		// Drain outstanding output
		src_valid = 1'b0;
		while (rewritten_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ http_chunked_body_decoder_unit.f @@
sv/hcbd_pkg.sv
sv/hcbd_front.sv
sv/hcbd_queue.sv
sv/hcbd_back.sv
sv/http_chunked_body_decoder_unit.sv
tb/http_chunked_body_decoder_unit_test.sv
